// ===== rtl/core/wpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and codes for the wheel period median meter with spi readout.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

    localparam int unsigned PERIOD_W  = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned FUNC_W    = 3;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DAT_W = 16;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_TICK0  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK1  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PULSE0 = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PULSE1 = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SPI    = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_BYTE = 4'd1;

    localparam logic [PERIOD_W-1:0] STALE_LIMIT_RST  = 16'd200;
    localparam logic [BYTE_W-1:0]   REQUEST_BYTE_RST = 8'hFF;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] spi_rx;
    } in_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   spi_tx;
        logic                spi_tx_loaded;
        logic [PERIOD_W-1:0] period_wheel0;
        logic [PERIOD_W-1:0] period_wheel1;
    } out_t;

    typedef struct packed {
        logic tick;
        logic pulse;
    } wheel_ctl_t;

    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] rx;
    } spi_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] tx;
        logic              loaded;
    } spi_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/wpm_wheel.sv =====
// ----------------------------------------------------------------------------
// wpm_wheel
// Tick counter, three-entry period history and median of one wheel.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_wheel (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire wpm_pkg::wheel_ctl_t          ctl,
    input  wire logic [wpm_pkg::PERIOD_W-1:0] stale_limit,
    output logic      [wpm_pkg::PERIOD_W-1:0] median_next
);

    typedef logic [wpm_pkg::PERIOD_W-1:0] period_t;

    function automatic period_t med3(input period_t a, input period_t b, input period_t c);
        period_t lo;
        period_t hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) begin
            return lo;
        end else if (c >= hi) begin
            return hi;
        end
        return c;
    endfunction

    period_t count_reg, count_next;
    period_t hist0_reg, hist0_next;
    period_t hist1_reg, hist1_next;
    period_t hist2_reg, hist2_next;
    period_t median_reg;
    period_t count_inc;

    assign count_inc = count_reg + period_t'(1);

    always_comb begin
        count_next  = count_reg;
        hist0_next  = hist0_reg;
        hist1_next  = hist1_reg;
        hist2_next  = hist2_reg;
        median_next = median_reg;
        if (ctl.tick) begin
            if (count_inc >= stale_limit) begin
                // wheel stopped
                count_next  = '0;
                hist0_next  = '0;
                hist1_next  = '0;
                hist2_next  = '0;
                median_next = '0;
            end else begin
                count_next = count_inc;
            end
        end else if (ctl.pulse) begin
            hist2_next  = hist1_reg;
            hist1_next  = hist0_reg;
            hist0_next  = count_reg;
            median_next = med3(count_reg, hist0_reg, hist1_reg);
            count_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            hist0_reg  <= '0;
            hist1_reg  <= '0;
            hist2_reg  <= '0;
            median_reg <= '0;
        end else begin
            count_reg  <= count_next;
            hist0_reg  <= hist0_next;
            hist1_reg  <= hist1_next;
            hist2_reg  <= hist2_next;
            median_reg <= median_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/wpm_spi.sv =====
// ----------------------------------------------------------------------------
// wpm_spi
// Four-byte little-endian readout of both medians, one byte per received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_spi (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire wpm_pkg::spi_req_t            req,
    input  wire logic [wpm_pkg::BYTE_W-1:0]   request_byte,
    input  wire logic [wpm_pkg::PERIOD_W-1:0] median0,
    input  wire logic [wpm_pkg::PERIOD_W-1:0] median1,
    output wpm_pkg::spi_rsp_t                 rsp
);

    logic [wpm_pkg::BYTE_W-1:0] snap_mem [4];

    logic       sending_reg, sending_next;
    logic [2:0] send_index_reg, send_index_next;
    logic [2:0] index_inc;
    logic       snap_write;

    assign index_inc = send_index_reg + 3'd1;

    always_comb begin
        sending_next    = sending_reg;
        send_index_next = send_index_reg;
        snap_write      = 1'b0;
        rsp             = '0;
        if (req.en) begin
            if (!sending_reg) begin
                if (req.rx == request_byte) begin
                    snap_write      = 1'b1;
                    rsp.tx          = median0[7:0];
                    rsp.loaded      = 1'b1;
                    sending_next    = 1'b1;
                    send_index_next = 3'd1;
                end
            end else begin
                rsp.tx     = snap_mem[send_index_reg[1:0]];
                rsp.loaded = 1'b1;
                if (index_inc[2]) begin
                    sending_next    = 1'b0;
                    send_index_next = '0;
                end else begin
                    send_index_next = index_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_write) begin
            snap_mem[0] <= median0[7:0];
            snap_mem[1] <= median0[15:8];
            snap_mem[2] <= median1[7:0];
            snap_mem[3] <= median1[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sending_reg    <= 1'b0;
            send_index_reg <= '0;
        end else begin
            sending_reg    <= sending_next;
            send_index_reg <= send_index_next;
        end
    end

    a_index_while_sending: assert property (@(posedge aclk) disable iff (!aresetn)
        sending_reg |-> (send_index_reg == 3'd1 || send_index_reg == 3'd2
                         || send_index_reg == 3'd3))
        else $error("send index out of range while sending");

    a_index_while_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !sending_reg |-> send_index_reg == 3'd0)
        else $error("send index not cleared while idle");

endmodule

`default_nettype wire

// ===== rtl/core/wheel_period_median_with_spi_readout.sv =====
// ----------------------------------------------------------------------------
// wheel_period_median_with_spi_readout
// Two-wheel pulse period meter with median-of-three filter and spi readout.
// ----------------------------------------------------------------------------
// Every request yields exactly one result. A request is captured in an input
// register, then combinational logic (tick counter increment and stale
// compare, median-of-three network, readout byte select) updates the wheel
// and readout state and fills the result register. Sustained rate is one
// request per clock while the result side keeps up. The result register
// frees itself in the cycle it is taken, so s_ready stays high as long as
// the result side keeps up. Configuration writes are taken at any time but
// should only be issued while the block is idle; index 0 sets stale_limit
// (16 bits, reset 200), index 1 sets request_byte (low 8 bits of cfg_data,
// reset 0xFF), other indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_period_median_with_spi_readout (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // request channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire wpm_pkg::in_t                  s_data,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output wpm_pkg::out_t                      m_data,
    // configuration channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [wpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wpm_pkg::CFG_DAT_W-1:0] cfg_data
);

    // configuration registers
    logic [wpm_pkg::PERIOD_W-1:0] stale_limit_reg;
    logic [wpm_pkg::BYTE_W-1:0]   request_byte_reg;

    // input stage
    wpm_pkg::in_t in_reg;
    logic         in_valid_reg;

    // result stage
    wpm_pkg::out_t out_reg, out_next;
    logic          out_valid_reg;

    // the compute stage moves when it holds a request and the result slot is free or being drained
    logic advance;

    wpm_pkg::wheel_ctl_t          ctl0, ctl1;
    wpm_pkg::spi_req_t            spi_req;
    wpm_pkg::spi_rsp_t            spi_rsp;
    logic [wpm_pkg::PERIOD_W-1:0] median0_next, median1_next;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stale_limit_reg  <= wpm_pkg::STALE_LIMIT_RST;
            request_byte_reg <= wpm_pkg::REQUEST_BYTE_RST;
        end else if (cfg_valid) begin
            priority if (cfg_index == wpm_pkg::REG_STALE_LIMIT) begin
                stale_limit_reg <= cfg_data;
            end else if (cfg_index == wpm_pkg::REG_REQUEST_BYTE) begin
                request_byte_reg <= cfg_data[wpm_pkg::BYTE_W-1:0];
            end else begin
                // unknown index, write dropped
            end
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // decode the request into per-unit strobes, gated by the stage advance
    always_comb begin
        ctl0    = '0;
        ctl1    = '0;
        spi_req = '0;
        spi_req.rx = in_reg.spi_rx;
        if (advance) begin
            unique case (in_reg.func)
                wpm_pkg::FUNC_TICK0:  ctl0.tick  = 1'b1;
                wpm_pkg::FUNC_TICK1:  ctl1.tick  = 1'b1;
                wpm_pkg::FUNC_PULSE0: ctl0.pulse = 1'b1;
                wpm_pkg::FUNC_PULSE1: ctl1.pulse = 1'b1;
                wpm_pkg::FUNC_SPI:    spi_req.en = 1'b1;
                default:              ; // unused codes change nothing
            endcase
        end
    end

    wpm_wheel u_wheel0 (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl0),
        .stale_limit (stale_limit_reg),
        .median_next (median0_next)
    );

    wpm_wheel u_wheel1 (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl1),
        .stale_limit (stale_limit_reg),
        .median_next (median1_next)
    );

    // snapshot uses the medians before this request, which a spi byte never changes
    wpm_spi u_spi (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req          (spi_req),
        .request_byte (request_byte_reg),
        .median0      (median0_next),
        .median1      (median1_next),
        .rsp          (spi_rsp)
    );

    always_comb begin
        out_next.spi_tx        = spi_rsp.tx;
        out_next.spi_tx_loaded = spi_rsp.loaded;
        out_next.period_wheel0 = median0_next;
        out_next.period_wheel1 = median1_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    a_advance_fills_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result register not filled after stage advance");

    a_no_load_without_spi: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_reg.func != wpm_pkg::FUNC_SPI) |=> !out_reg.spi_tx_loaded)
        else $error("spi byte loaded by a non-spi request");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("request refused while input stage empty");

    a_unloaded_tx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !spi_rsp.loaded |=> out_reg.spi_tx == '0)
        else $error("spi byte nonzero without a load");

endmodule

`default_nettype wire
